[design/msfp_pkg.sv]
// Package with the item types and constants shared by the motor status frame parser.
`default_nettype none
package msfp_pkg;

    // Default number of bytes in one status frame.
    localparam int FRAME_LEN_DEF = 24;

    // Byte counter width; it covers frame lengths up to 32.
    localparam int CNT_W = 5;

    // Alternate sum that is also accepted when byte 0 equals one.
    localparam logic [7:0] QUIRK_SUM = 8'd253;
    localparam logic [7:0] QUIRK_BYTE0 = 8'd1;

    // Byte positions of the fields inside a frame.
    localparam int RECEIVER_IDX = 0;
    localparam int SENDER_IDX = 1;
    localparam int DEVICE_IDX = 2;
    localparam int PARAM_IDX = 3;
    localparam int COUNT_IDX = 4;
    localparam int RIGHT_RPM_IDX = 5;
    localparam int RIGHT_STATE_IDX = 9;
    localparam int RIGHT_POS_IDX = 10;
    localparam int LEFT_RPM_IDX = 14;
    localparam int LEFT_STATE_IDX = 18;
    localparam int LEFT_POS_IDX = 19;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic               checksum_ok;
        logic [7:0]         receiver_id;
        logic [7:0]         sender_id;
        logic [7:0]         device_id;
        logic [7:0]         parameter_id;
        logic [7:0]         data_count;
        logic signed [15:0] right_rpm;
        logic [7:0]         right_state;
        logic signed [31:0] right_position;
        logic signed [15:0] left_rpm;
        logic [7:0]         left_state;
        logic signed [31:0] left_position;
    } out_item_t;

endpackage
`default_nettype wire

[design/motor_status_frame_parser.sv]
// Top level of the motor status frame parser.
`default_nettype none
// Takes one frame byte per cycle and gives one result on the last byte of each
// FRAME_LEN-byte frame; a byte with frame_start set restarts the frame as byte 0.
// Bytes move through a line of FRAME_LEN-1 byte cells, so at the last byte every
// field sits at a fixed cell or on the input, while a running 8-bit sum checks the
// frame. A good frame (sum zero, or byte 0 equal to one with sum 253) updates the
// held fields; a bad one repeats the last good fields with checksum_ok clear. The
// result sits in an output register, and bytes keep flowing while it waits, except
// that the closing byte of a frame is held off until the previous result has been
// taken. Throughput is one byte per cycle when no closing byte is held off; a result
// appears in the cycle after its last byte is taken.
module motor_status_frame_parser #(
    parameter int FRAME_LEN = msfp_pkg::FRAME_LEN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire msfp_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output msfp_pkg::out_item_t      m_item
);

    localparam int NCELL = FRAME_LEN - 1;
    localparam int FIELD_BYTES = msfp_pkg::LEFT_POS_IDX + 4;
    localparam logic [msfp_pkg::CNT_W-1:0] LAST_IDX = msfp_pkg::CNT_W'(FRAME_LEN - 1);

    logic [msfp_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]                 sum_reg, sum_next;
    logic                       m_valid_reg, m_valid_next;
    msfp_pkg::out_item_t        m_item_reg, m_item_next;

    logic [msfp_pkg::CNT_W-1:0] idx;
    logic                       accept;
    logic                       is_last;
    logic [7:0]                 frame_sum;
    logic                       frame_ok;
    logic [7:0]                 cell_q [NCELL];
    logic [7:0]                 frame_byte [FIELD_BYTES];

    // Cell 0 takes the incoming byte; at the last byte, frame byte k is in
    // cell FRAME_LEN-2-k.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        if (i == 0) begin : g_head
            msfp_cell u_cell (
                .aclk    (aclk),
                .shift_en(accept),
                .d_in    (s_item.data_byte),
                .d_out   (cell_q[i])
            );
        end else begin : g_body
            msfp_cell u_cell (
                .aclk    (aclk),
                .shift_en(accept),
                .d_in    (cell_q[i-1]),
                .d_out   (cell_q[i])
            );
        end
    end

    // In the shortest frame the last field byte is the closing byte itself.
    for (genvar j = 0; j < FIELD_BYTES; j++) begin : g_byte
        if (j == FRAME_LEN - 1) begin : g_in
            assign frame_byte[j] = s_item.data_byte;
        end else begin : g_stored
            assign frame_byte[j] = cell_q[NCELL-1-j];
        end
    end

    assign s_ready = !(m_valid_reg && !m_ready && (byte_count_reg == LAST_IDX));
    assign accept  = s_valid && s_ready;

    assign idx       = s_item.frame_start ? '0 : byte_count_reg;
    assign is_last   = (idx == LAST_IDX);
    assign frame_sum = ((idx == '0) ? 8'd0 : sum_reg) + s_item.data_byte;
    assign frame_ok  = (frame_sum == 8'd0) ||
                       ((frame_byte[msfp_pkg::RECEIVER_IDX] == msfp_pkg::QUIRK_BYTE0) &&
                        (frame_sum == msfp_pkg::QUIRK_SUM));

    always_comb begin
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        if (accept) begin
            byte_count_next = is_last ? '0 : idx + 1'b1;
            sum_next        = is_last ? 8'd0 : frame_sum;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && is_last) begin
            m_valid_next            = 1'b1;
            m_item_next.checksum_ok = frame_ok;
            if (frame_ok) begin
                m_item_next.receiver_id    = frame_byte[msfp_pkg::RECEIVER_IDX];
                m_item_next.sender_id      = frame_byte[msfp_pkg::SENDER_IDX];
                m_item_next.device_id      = frame_byte[msfp_pkg::DEVICE_IDX];
                m_item_next.parameter_id   = frame_byte[msfp_pkg::PARAM_IDX];
                m_item_next.data_count     = frame_byte[msfp_pkg::COUNT_IDX];
                m_item_next.right_rpm      = {frame_byte[msfp_pkg::RIGHT_RPM_IDX + 1],
                                              frame_byte[msfp_pkg::RIGHT_RPM_IDX]};
                m_item_next.right_state    = frame_byte[msfp_pkg::RIGHT_STATE_IDX];
                m_item_next.right_position = {frame_byte[msfp_pkg::RIGHT_POS_IDX + 3],
                                              frame_byte[msfp_pkg::RIGHT_POS_IDX + 2],
                                              frame_byte[msfp_pkg::RIGHT_POS_IDX + 1],
                                              frame_byte[msfp_pkg::RIGHT_POS_IDX]};
                m_item_next.left_rpm       = {frame_byte[msfp_pkg::LEFT_RPM_IDX + 1],
                                              frame_byte[msfp_pkg::LEFT_RPM_IDX]};
                m_item_next.left_state     = frame_byte[msfp_pkg::LEFT_STATE_IDX];
                m_item_next.left_position  = {frame_byte[msfp_pkg::LEFT_POS_IDX + 3],
                                              frame_byte[msfp_pkg::LEFT_POS_IDX + 2],
                                              frame_byte[msfp_pkg::LEFT_POS_IDX + 1],
                                              frame_byte[msfp_pkg::LEFT_POS_IDX]};
            end
        end
    end

    // The result register also keeps the last good fields, so it is reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            sum_reg        <= '0;
            m_valid_reg    <= 1'b0;
            m_item_reg     <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
            sum_reg        <= sum_next;
            m_valid_reg    <= m_valid_next;
            m_item_reg     <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
`default_nettype wire

[design/msfp_cell.sv]
// One byte cell of the frame shift line.
`default_nettype none
module msfp_cell (
    input  wire logic       aclk,
    input  wire logic       shift_en,
    input  wire logic [7:0] d_in,
    output logic      [7:0] d_out
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= d_in;
        end
    end

    assign d_out = byte_reg;

endmodule
`default_nettype wire
